/* rtl/sle_pkg.sv */
// Shared types, constants and codes for the serial line editor.
package sle_pkg;

    localparam int BYTE_W             = 8;
    localparam int MAX_LINE_W         = 6;
    localparam int LINE_DEPTH_DEFAULT = 32;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;

    localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;
    localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;

    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // register index as decoded from paddr[2]
    localparam logic REG_ECHO_ENABLE = 1'b0;
    localparam logic REG_MAX_LINE    = 1'b1;

    localparam logic                  ECHO_ENABLE_RESET = 1'b1;
    localparam logic [MAX_LINE_W-1:0] MAX_LINE_RESET    = 6'd32;

    typedef struct packed {
        logic                  echo_enable;
        logic [MAX_LINE_W-1:0] max_line;
    } cfg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LINE_RD,
        S_LINE_OUT,
        S_EDIT,
        S_ECHO
    } seq_state_t;

endpackage

/* rtl/sle_if.sv */
// Valid/ready channel interfaces for received bytes and results.
interface sle_rx_if;
    logic                        valid;
    logic                        ready;
    logic [sle_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sle_res_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [sle_pkg::BYTE_W-1:0]  result_byte;
    logic                        line_cut;
    logic                        last_of_run;

    modport source (output valid, output result_kind, output result_byte,
                    output line_cut, output last_of_run, input ready);
    modport sink   (input valid, input result_kind, input result_byte,
                    input line_cut, input last_of_run, output ready);
endinterface

/* rtl/sle_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/sle_cfg_regs.sv */
// APB configuration registers: echo enable and line limit.
module sle_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sle_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sle_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sle_pkg::APB_DATA_W-1:0]   prdata,
    output sle_pkg::cfg_t                    cfg
);

    logic                              echo_enable_reg;
    logic                              echo_enable_next;
    logic [sle_pkg::MAX_LINE_W-1:0]    max_line_reg;
    logic [sle_pkg::MAX_LINE_W-1:0]    max_line_next;
    logic                              wr_hit;
    logic                              reg_idx;

    assign reg_idx = paddr[2];
    assign wr_hit  = psel && penable && pwrite;

    always_comb
    begin
        echo_enable_next = echo_enable_reg;
        max_line_next    = max_line_reg;
        if (wr_hit)
        begin
            unique case (reg_idx)
                sle_pkg::REG_ECHO_ENABLE: echo_enable_next = pwdata[0];
                sle_pkg::REG_MAX_LINE:    max_line_next = pwdata[sle_pkg::MAX_LINE_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_enable_reg <= sle_pkg::ECHO_ENABLE_RESET;
            max_line_reg    <= sle_pkg::MAX_LINE_RESET;
        end
        else
        begin
            echo_enable_reg <= echo_enable_next;
            max_line_reg    <= max_line_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sle_pkg::REG_ECHO_ENABLE:
                prdata = {{(sle_pkg::APB_DATA_W-1){1'b0}}, echo_enable_reg};
            sle_pkg::REG_MAX_LINE:
                prdata = {{(sle_pkg::APB_DATA_W-sle_pkg::MAX_LINE_W){1'b0}}, max_line_reg};
            default:
                prdata = '0;
        endcase
    end

    assign cfg.echo_enable = echo_enable_reg;
    assign cfg.max_line    = max_line_reg;

endmodule

/* rtl/sle_seq.sv */
// Editing sequencer: fill count, line store access, echo and line emission.
module sle_seq #(
    parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sle_pkg::cfg_t         cfg,
    sle_rx_if.sink                rx,
    sle_res_if.source             res
);

    localparam int FILL_W = $clog2(LINE_DEPTH + 1);
    localparam int ADDR_W = $clog2(LINE_DEPTH);
    localparam int B_W    = sle_pkg::BYTE_W;

    sle_pkg::seq_state_t state_reg, state_next;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] len_reg, len_next;
    logic [FILL_W-1:0] idx_reg, idx_next;
    logic [1:0]        echo_idx_reg, echo_idx_next;
    logic [B_W-1:0]    char_reg, char_next;
    logic              erase_reg, erase_next;
    logic              lf_reg, lf_next;
    logic              cut_phase_reg, cut_phase_next;
    logic              tail_reg, tail_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_kind_reg, out_kind_next;
    logic [B_W-1:0]    out_byte_reg, out_byte_next;
    logic              out_cut_reg, out_cut_next;
    logic              out_last_reg, out_last_next;

    logic              can_push;
    logic [FILL_W-1:0] lim;
    logic [B_W-1:0]    in_char;
    logic              in_erase;
    logic              in_lf;
    logic [1:0]        echo_last_idx;
    logic [B_W-1:0]    echo_byte;
    logic              line_end;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [B_W-1:0]    rd_data;

    sle_ram #(
        .WIDTH (B_W),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (char_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // limit = clamp(max_line, 2, LINE_DEPTH) - 1
    always_comb
    begin
        if ({1'b0, cfg.max_line} > (sle_pkg::MAX_LINE_W + 1)'(LINE_DEPTH))
        begin
            lim = FILL_W'(LINE_DEPTH - 1);
        end
        else if (cfg.max_line < sle_pkg::MAX_LINE_W'(2))
        begin
            lim = FILL_W'(1);
        end
        else
        begin
            lim = FILL_W'(cfg.max_line - sle_pkg::MAX_LINE_W'(1));
        end
    end

    assign in_char  = (rx.rx_byte == sle_pkg::CH_CR) ? sle_pkg::CH_LF : rx.rx_byte;
    assign in_erase = (in_char == sle_pkg::CH_BS) || (in_char == sle_pkg::CH_DEL);
    assign in_lf    = (in_char == sle_pkg::CH_LF);

    assign can_push = !out_valid_reg || res.ready;
    assign line_end = (idx_reg == FILL_W'(len_reg - 1'b1));

    // echo sequence: erase 08 20 08, LF as CR LF, else the byte itself
    always_comb
    begin
        if (erase_reg)
        begin
            echo_last_idx = 2'd2;
            echo_byte     = (echo_idx_reg == 2'd1) ? sle_pkg::CH_SP : sle_pkg::CH_BS;
        end
        else if (lf_reg)
        begin
            echo_last_idx = 2'd1;
            echo_byte     = (echo_idx_reg == 2'd0) ? sle_pkg::CH_CR : sle_pkg::CH_LF;
        end
        else
        begin
            echo_last_idx = 2'd0;
            echo_byte     = char_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        echo_idx_next  = echo_idx_reg;
        char_next      = char_reg;
        erase_next     = erase_reg;
        lf_next        = lf_reg;
        cut_phase_next = cut_phase_reg;
        tail_next      = tail_reg;

        out_valid_next = out_valid_reg && !res.ready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_cut_next   = out_cut_reg;
        out_last_next  = out_last_reg;

        rx.ready = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = fill_reg[ADDR_W-1:0];
        rd_en    = 1'b0;
        rd_addr  = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            sle_pkg::S_IDLE:
            begin
                rx.ready = 1'b1;
                if (rx.valid)
                begin
                    char_next  = in_char;
                    erase_next = in_erase;
                    lf_next    = in_lf;
                    if (fill_reg >= lim)
                    begin
                        // full line goes out first, flagged as cut
                        len_next       = fill_reg;
                        fill_next      = '0;
                        idx_next       = '0;
                        cut_phase_next = 1'b1;
                        tail_next      = in_erase || (!cfg.echo_enable && !in_lf);
                        state_next     = sle_pkg::S_LINE_RD;
                    end
                    else
                    begin
                        state_next = sle_pkg::S_EDIT;
                    end
                end
            end

            sle_pkg::S_EDIT:
            begin
                echo_idx_next = '0;
                if (erase_reg)
                begin
                    if (fill_reg != '0)
                    begin
                        fill_next  = FILL_W'(fill_reg - 1'b1);
                        state_next = cfg.echo_enable ? sle_pkg::S_ECHO : sle_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = sle_pkg::S_IDLE;
                    end
                end
                else
                begin
                    wr_en = 1'b1;
                    if (lf_reg)
                    begin
                        len_next       = FILL_W'(fill_reg + 1'b1);
                        fill_next      = '0;
                        idx_next       = '0;
                        cut_phase_next = 1'b0;
                        tail_next      = 1'b1;
                    end
                    else
                    begin
                        fill_next = FILL_W'(fill_reg + 1'b1);
                    end
                    if (cfg.echo_enable)
                    begin
                        state_next = sle_pkg::S_ECHO;
                    end
                    else
                    begin
                        state_next = lf_reg ? sle_pkg::S_LINE_RD : sle_pkg::S_IDLE;
                    end
                end
            end

            sle_pkg::S_ECHO:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = sle_pkg::KIND_ECHO;
                    out_byte_next  = echo_byte;
                    out_cut_next   = 1'b0;
                    out_last_next  = (echo_idx_reg == echo_last_idx) && !lf_reg;
                    if (echo_idx_reg == echo_last_idx)
                    begin
                        state_next = lf_reg ? sle_pkg::S_LINE_RD : sle_pkg::S_IDLE;
                    end
                    else
                    begin
                        echo_idx_next = echo_idx_reg + 2'd1;
                    end
                end
            end

            sle_pkg::S_LINE_RD:
            begin
                rd_en      = 1'b1;
                state_next = sle_pkg::S_LINE_OUT;
            end

            sle_pkg::S_LINE_OUT:
            begin
                if (can_push)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = sle_pkg::KIND_LINE;
                    out_byte_next  = rd_data;
                    out_cut_next   = cut_phase_reg;
                    out_last_next  = line_end && tail_reg;
                    if (line_end)
                    begin
                        state_next = cut_phase_reg ? sle_pkg::S_EDIT : sle_pkg::S_IDLE;
                    end
                    else
                    begin
                        // fetch the next character while this one is handed over
                        idx_next = FILL_W'(idx_reg + 1'b1);
                        rd_en    = 1'b1;
                        rd_addr  = idx_next[ADDR_W-1:0];
                    end
                end
            end

            default:
            begin
                state_next = sle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sle_pkg::S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        echo_idx_reg  <= echo_idx_next;
        char_reg      <= char_next;
        erase_reg     <= erase_next;
        lf_reg        <= lf_next;
        cut_phase_reg <= cut_phase_next;
        tail_reg      <= tail_next;
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_cut_reg   <= out_cut_next;
        out_last_reg  <= out_last_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.result_kind = out_kind_reg;
    assign res.result_byte = out_byte_reg;
    assign res.line_cut    = out_cut_reg;
    assign res.last_of_run = out_last_reg;

endmodule

/* rtl/serial_line_editor_core.sv */
// Top level of the serial line editor: config registers and editing sequencer.
//
//  channel   dir  handshake      payload
//  -------   ---  -------------  ----------------------------------------------
//  rx        in   valid/ready    rx_byte
//  res       out  valid/ready    result_kind, result_byte, line_cut, last_of_run
//  apb       in   psel/penable   paddr, pwdata -> prdata (pready tied high)
//
// One received byte at a time; each goes through the edit state and then up to
// 3 echo bytes. Each emitted line starts with a line-store read, and the next
// character is fetched while one is handed over; the single read port of the
// line store sets that pace. A cut line and an LF line can both follow one
// byte. Reset clears the fill count, the state and the output valid; the line
// store needs no clearing since only written entries are read. Stalled results
// hold the sequencer; input waits for the run's last result to be registered.
module serial_line_editor_core #(
    parameter int LINE_DEPTH = sle_pkg::LINE_DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    sle_rx_if.sink                           rx,
    sle_res_if.source                        res,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sle_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sle_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sle_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    sle_pkg::cfg_t cfg;

    // zero-wait-state register port
    assign pready = 1'b1;

    sle_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sequencer owns the line store and the output register
    sle_seq #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .rx    (rx),
        .res   (res)
    );

endmodule

/* rtl/sle_checker.sv */
// Port-level checks for the serial line editor, bound to the top level.
module sle_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic                           out_kind,
    input logic [sle_pkg::BYTE_W-1:0]     out_byte,
    input logic                           out_cut,
    input logic                           out_last
);

    // stalled result holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(out_kind) && $stable(out_last))
        else $error("result changed while stalled");

    // one byte in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a byte is in work");

    // only line bytes can carry the cut flag
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_cut |-> out_kind == sle_pkg::KIND_LINE)
        else $error("cut flag on an echo byte");

    // when ready for the next byte, any pending result ends its run
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && out_valid |-> out_last)
        else $error("run incomplete while accepting input");

endmodule

bind serial_line_editor_core sle_checker u_sle_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_kind  (res.result_kind),
    .out_byte  (res.result_byte),
    .out_cut   (res.line_cut),
    .out_last  (res.last_of_run)
);

/* bench/serial_line_editor_core_test.sv */
// Self-checking testbench for serial_line_editor_core: line editing, echo and length cuts.
module serial_line_editor_core_test;

    import sle_pkg::*;

    localparam int DEPTH        = LINE_DEPTH_DEFAULT;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 8;
    // a byte that causes no result still passes through the edit state before the sequencer is idle again
    localparam int QUIET_CYCLES = 12;
    // hard stop time, with a wide margin over the slowest legal run
    localparam int RUN_LIMIT    = 12 * 3_000_000;

    // byte addresses of the two registers, decoded by the block from paddr[2]
    localparam logic [APB_ADDR_W-1:0] ADDR_ECHO_ENABLE = {REG_ECHO_ENABLE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_LINE    = {REG_MAX_LINE, 2'b00};

    // one expected result transfer
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data;
        logic              cut;
        logic              last;
    } editor_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sle_rx_if  rx_ch ();
    sle_res_if res_ch ();

    serial_line_editor_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Editor model: its own copy of the registers, the line store and the
    // fill count. Expected result transfers queue up in expected_out.
    // ------------------------------------------------------------------
    cfg_t              model_cfg;
    logic [BYTE_W-1:0] model_line [DEPTH];
    int                model_fill;
    editor_out_t       expected_out [$];

    // stimulus bookkeeping
    logic [BYTE_W-1:0] pending_bytes [$];
    int                bytes_queued;
    int                bytes_offered;
    int                bytes_taken;
    int                results_seen;
    int                error_count;
    int                lines_done;
    int                cut_lines;
    int                erases_done;
    int                sender_idle_pct;
    int                receiver_idle_pct;
    logic              sender_hold;

    function automatic void push_out(logic kind, logic [BYTE_W-1:0] data, logic cut);
        editor_out_t r;
        r.kind = kind;
        r.data = data;
        r.cut  = cut;
        r.last = 1'b0;
        expected_out.push_back(r);
    endfunction

    // Send the stored characters out in order and empty the line.
    function automatic void flush_line(logic cut);
        for (int i = 0; i < model_fill && i < DEPTH; i++)
            push_out(KIND_LINE, model_line[i], cut);
        if (model_fill != 0) begin
            lines_done++;
            if (cut)
                cut_lines++;
        end
        model_fill = 0;
    endfunction

    // Expected transfers for one received byte.
    function automatic void edit_byte(logic [BYTE_W-1:0] rx_in);
        logic [BYTE_W-1:0] c;
        int                limit;
        int                first;
        editor_out_t       tail;
        first = expected_out.size();
        // register value clamps to 2..DEPTH; the line holds one less than that
        if (model_cfg.max_line < 2)
            limit = 1;
        else if (model_cfg.max_line > DEPTH)
            limit = DEPTH - 1;
        else
            limit = int'(model_cfg.max_line) - 1;

        // line full: the pending line goes out cut, before this byte is looked at
        if (model_fill >= limit)
            flush_line(1'b1);

        c = (rx_in == CH_CR) ? CH_LF : rx_in;

        if (c == CH_BS || c == CH_DEL) begin
            // erase on an empty line is silent
            if (model_fill != 0) begin
                model_fill--;
                erases_done++;
                if (model_cfg.echo_enable) begin
                    push_out(KIND_ECHO, CH_BS, 1'b0);
                    push_out(KIND_ECHO, CH_SP, 1'b0);
                    push_out(KIND_ECHO, CH_BS, 1'b0);
                end
            end
        end else begin
            if (model_cfg.echo_enable) begin
                if (c == CH_LF)
                    push_out(KIND_ECHO, CH_CR, 1'b0);
                push_out(KIND_ECHO, c, 1'b0);
            end
            if (model_fill < DEPTH) begin
                model_line[model_fill] = c;
                model_fill++;
            end
            if (c == CH_LF)
                flush_line(1'b0);
        end

        // mark the final transfer of this byte's run
        if (expected_out.size() > first) begin
            tail = expected_out.pop_back();
            tail.last = 1'b1;
            expected_out.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset. Every block input gets a known value at time zero.
    // ------------------------------------------------------------------
    initial begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        rx_ch.valid    = 1'b0;
        rx_ch.rx_byte  = '0;
        res_ch.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // rx driver: a byte transfer happens on valid && ready at the edge.
    // The next byte is offered once the slot is free, unless the sender
    // idles this cycle or is held off.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= '0;
        end else begin
            if (rx_ch.valid && rx_ch.ready) begin
                edit_byte(rx_ch.rx_byte);
                bytes_taken++;
            end
            if (!rx_ch.valid || rx_ch.ready) begin
                if (pending_bytes.size() != 0 && !sender_hold
                    && $urandom_range(0, 99) >= sender_idle_pct) begin
                    rx_ch.valid   <= 1'b1;
                    rx_ch.rx_byte <= pending_bytes.pop_front();
                    bytes_offered++;
                end else begin
                    rx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: each transfer is checked against the oldest
    // expectation; ready is redrawn every cycle.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        editor_out_t want;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (expected_out.size() == 0) begin
                    $error("unexpected result: kind %0b byte %h cut %0b last %0b",
                           res_ch.result_kind, res_ch.result_byte,
                           res_ch.line_cut, res_ch.last_of_run);
                    error_count++;
                end else begin
                    want = expected_out.pop_front();
                    if (res_ch.result_kind !== want.kind) begin
                        $error("result_kind: expected %0b, got %0b",
                               want.kind, res_ch.result_kind);
                        error_count++;
                    end
                    if (res_ch.result_byte !== want.data) begin
                        $error("result_byte: expected %h, got %h",
                               want.data, res_ch.result_byte);
                        error_count++;
                    end
                    if (res_ch.line_cut !== want.cut) begin
                        $error("line_cut: expected %0b, got %0b",
                               want.cut, res_ch.line_cut);
                        error_count++;
                    end
                    if (res_ch.last_of_run !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b",
                               want.last, res_ch.last_of_run);
                        error_count++;
                    end
                end
            end
            res_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    // APB write: setup cycle, then access until pready; the model follows
    // once the write edge has passed.
    task automatic cfg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ECHO_ENABLE)
            model_cfg.echo_enable = data[0];
        else if (addr == ADDR_MAX_LINE)
            model_cfg.max_line = data[MAX_LINE_W-1:0];
    endtask

    // Let every queued byte go through and every result drain, then give a
    // silent last byte time to finish before the registers are touched.
    task automatic wait_idle();
        while (bytes_taken != bytes_queued || expected_out.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic echo, input logic [MAX_LINE_W-1:0] limit);
        wait_idle();
        // upper bits of pwdata are random; only the low field should matter
        cfg_write(ADDR_ECHO_ENABLE, {16'($urandom_range(0, 65535)), 15'd0, echo});
        cfg_write(ADDR_MAX_LINE, {16'($urandom_range(0, 65535)), 10'd0, limit});
    endtask

    // Mostly typed lines with random text and occasional erases, ended by CR
    // or LF; some lines run past the limit, some are left unterminated, and
    // some bursts are raw byte noise.
    task automatic queue_random(input int target);
        int added;
        int flavor;
        int len;
        added = 0;
        while (added < target) begin
            flavor = $urandom_range(0, 9);
            if (flavor == 0) begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    queue_byte(8'($urandom_range(0, 255)));
                    added++;
                end
            end else begin
                len = (flavor == 1) ? $urandom_range(25, 40) : $urandom_range(0, 10);
                repeat (len) begin
                    if ($urandom_range(0, 7) == 0)
                        queue_byte($urandom_range(0, 1) ? CH_BS : CH_DEL);
                    else
                        queue_byte(8'($urandom_range(8'h20, 8'h7E)));
                    added++;
                end
                // flavor 2 leaves the line open for the next one to run into
                if (flavor != 2) begin
                    queue_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
                    added++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int mark;
        model_cfg.echo_enable = ECHO_ENABLE_RESET;
        model_cfg.max_line    = MAX_LINE_RESET;
        model_fill            = 0;
        bytes_queued          = 0;
        bytes_offered         = 0;
        bytes_taken           = 0;
        results_seen          = 0;
        error_count           = 0;
        lines_done            = 0;
        cut_lines             = 0;
        erases_done           = 0;
        sender_hold           = 1'b0;
        sender_idle_pct       = 16;
        receiver_idle_pct     = 72;

        @(posedge rst_n);
        @(posedge clk);

        // Directed, reset registers (echo on, limit 32): all-zero and all-one
        // bytes, both erase codes, CR turned into LF, erases on an empty line,
        // and a bare LF line.
        queue_byte(8'h41);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_BS);
        queue_byte(CH_DEL);
        queue_byte(CH_CR);
        queue_byte(CH_BS);
        queue_byte(CH_DEL);
        queue_byte(CH_LF);

        // Smallest limit: one character per line, so each of the next two bytes
        // cuts the line before it, and the final erase finds the line empty.
        set_config(1'b1, 6'd2);
        queue_byte(8'h78);
        queue_byte(8'h79);
        queue_byte(CH_LF);
        queue_byte(CH_BS);

        // Echo off, limit below range (acts as 2): an erase on a full line
        // cuts it first and then finds the line empty.
        set_config(1'b0, 6'd1);
        queue_byte(8'h70);
        queue_byte(8'h71);
        queue_byte(CH_DEL);
        queue_byte(8'h72);
        queue_byte(CH_CR);

        // Echo on, limit above the store depth (acts as the depth).
        set_config(1'b1, 6'd63);
        queue_byte(8'h68);
        queue_byte(8'h69);
        queue_byte(CH_BS);
        queue_byte(8'h6F);
        queue_byte(8'h7E);
        queue_byte(8'h80);
        queue_byte(CH_LF);

        // Random part, first with a slow receiver.
        set_config(1'b1, 6'd32);
        queue_random(50);
        set_config(1'b0, 6'd0);
        queue_random(25);

        // Slow sender, quick receiver.
        wait_idle();
        sender_idle_pct   = 72;
        receiver_idle_pct = 16;
        set_config(1'b1, 6'd5);
        queue_random(40);
        set_config(1'b1, 6'd63);
        queue_random(15);

        // No idling on either side; midway the sender stops until the
        // block has drained completely.
        wait_idle();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        set_config(1'b0, 6'($urandom_range(2, DEPTH)));
        queue_random(35);
        mark = bytes_queued - 20;
        while (bytes_offered < mark)
            @(posedge clk);
        sender_hold = 1'b1;
        @(posedge clk);
        @(posedge clk);
        while (bytes_taken != bytes_offered || expected_out.size() != 0)
            @(posedge clk);
        sender_hold = 1'b0;
        set_config(1'b1, 6'd17);
        queue_random(40);

        // Drain and let the block settle.
        while (bytes_taken != bytes_queued || expected_out.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        if (expected_out.size() != 0) begin
            $error("%0d expected results never arrived", expected_out.size());
            error_count++;
        end

        $display("Sent %0d bytes, checked %0d result transfers.", bytes_taken, results_seen);
        $display("Lines out: %0d (%0d cut at the limit); erases applied: %0d.",
                 lines_done, cut_lines, erases_done);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
rtl/sle_pkg.sv
rtl/sle_if.sv
rtl/sle_ram.sv
rtl/sle_cfg_regs.sv
rtl/sle_seq.sv
rtl/serial_line_editor_core.sv
rtl/sle_checker.sv
bench/serial_line_editor_core_test.sv
